// ===== rtl/fem_pkg.sv =====
`default_nettype none

package fem_pkg;

  // delay line geometry
  localparam int DELAY_DEPTH = 8192;
  localparam int ADDR_W      = $clog2(DELAY_DEPTH);

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int LEN_W    = 13;
  localparam int GAIN_W   = 8;
  localparam int WIDE_W   = 22;

  // register reset values
  localparam logic [LEN_W-1:0]  DELAY_LENGTH_RST = LEN_W'(64);
  localparam logic [GAIN_W-1:0] MIC_GAIN_RST     = GAIN_W'(50);
  localparam logic [GAIN_W-1:0] MUSIC_GAIN_RST   = GAIN_W'(30);

  // saturation limits
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    REG_ECHO_RUNNING = 2'd0,
    REG_DELAY_LENGTH = 2'd1,
    REG_MIC_GAIN     = 2'd2,
    REG_MUSIC_GAIN   = 2'd3
  } reg_idx_t;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // access request from the datapath to the delay line
  typedef struct packed {
    logic    rd_en;
    addr_t   rd_addr;
    logic    wr_en;
    addr_t   wr_addr;
    sample_t wr_data;
  } dl_req_t;

  typedef struct packed {
    sample_t out_left;
    sample_t out_right;
    sample_t feedback;
  } mix_res_t;

  // highest usable index, clamped to the store
  function automatic addr_t eff_len(input logic [LEN_W-1:0] len);
    if (32'(len) >= DELAY_DEPTH) begin
      return ADDR_W'(DELAY_DEPTH - 1);
    end
    return ADDR_W'(len);
  endfunction

  function automatic sample_t sat16(input logic signed [WIDE_W-1:0] v);
    if (v > WIDE_W'(SAMPLE_MAX)) begin
      return SAMPLE_MAX;
    end
    if (v < WIDE_W'(SAMPLE_MIN)) begin
      return SAMPLE_MIN;
    end
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fem_mix.sv =====
`default_nettype none

module fem_mix (
  input  wire fem_pkg::sample_t          tap,
  input  wire fem_pkg::sample_t          mic_left,
  input  wire fem_pkg::sample_t          mic_right,
  input  wire fem_pkg::sample_t          music_left,
  input  wire fem_pkg::sample_t          music_right,
  input  wire logic                      music_present,
  input  wire logic [fem_pkg::GAIN_W-1:0] mic_gain,
  input  wire logic [fem_pkg::GAIN_W-1:0] music_gain,
  output fem_pkg::mix_res_t              res
);

  logic signed [16:0] tap_mic;
  logic signed [25:0] wet_prod;
  logic signed [24:0] mus_l_prod;
  logic signed [24:0] mus_r_prod;
  fem_pkg::sample_t   wet;
  logic signed [fem_pkg::WIDE_W-1:0] sum_l;
  logic signed [fem_pkg::WIDE_W-1:0] sum_r;
  logic signed [16:0] fb_sum;

  // the dropped low bits give floor division by sixteen
  assign tap_mic    = {tap[15], tap} + {mic_left[15], mic_left};
  assign wet_prod   = tap_mic * $signed({1'b0, mic_gain});
  assign mus_l_prod = music_left * $signed({1'b0, music_gain});
  assign mus_r_prod = music_right * $signed({1'b0, music_gain});

  assign wet   = fem_pkg::sat16(wet_prod[25:4]);
  assign sum_l = {mus_l_prod[24], mus_l_prod[24:4]} + {{6{wet[15]}}, wet};
  assign sum_r = {mus_r_prod[24], mus_r_prod[24:4]} + {{6{wet[15]}}, wet};

  // half the tap, rounded down, plus the right mic
  assign fb_sum = {tap[15], tap[15], tap[15:1]} + {mic_right[15], mic_right};

  always_comb begin
    res.feedback = fem_pkg::sat16({{5{fb_sum[16]}}, fb_sum});
    if (music_present) begin
      res.out_left  = fem_pkg::sat16(sum_l);
      res.out_right = fem_pkg::sat16(sum_r);
    end else begin
      res.out_left  = wet;
      res.out_right = wet;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fem_delay_line.sv =====
`default_nettype none

module fem_delay_line (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             clear_start,
  input  wire fem_pkg::dl_req_t req,
  output fem_pkg::sample_t      rd_data,
  output logic                  busy
);

  fem_pkg::sample_t mem [fem_pkg::DELAY_DEPTH];
  fem_pkg::sample_t q;
  fem_pkg::sample_t fwd_data;
  logic             fwd_hit;
  fem_pkg::addr_t   sweep;

  // zeroing sweep, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst || clear_start) begin
      busy  <= 1'b1;
      sweep <= '0;
    end else if (busy) begin
      sweep <= sweep + 1'b1;
      if (sweep == fem_pkg::ADDR_W'(fem_pkg::DELAY_DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[sweep] <= '0;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      q <= mem[req.rd_addr];
    end
  end

  // a read that meets a write to the same entry takes the new value
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (req.rd_en) begin
      fwd_hit <= req.wr_en && (req.wr_addr == req.rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      fwd_data <= req.wr_data;
    end
  end

  assign rd_data = fwd_hit ? fwd_data : q;

endmodule

`default_nettype wire

// ===== rtl/feedback_echo_mixer_core.sv =====
// Karaoke echo mixer. One stereo frame goes in per item and one mixed frame
// comes out. Throughput is one item per clock while in_stall is low; the
// tap is read from the delay line into stage one when the item is accepted,
// and the mix lands in the output register when stage one advances. The
// delay line is an 8192 x 16 single-port-write memory. After reset, and
// after every write to echo_running or delay_length, the memory is zeroed
// by a sweep over all DELAY_DEPTH (8192) entries during which in_stall stays
// high; register writes are still taken then. Registers sit at byte addresses
// 0, 4, 8, 12 (echo_running, delay_length, mic_gain, music_gain) and read
// back the written value cut to each field's width.
`default_nettype none

module feedback_echo_mixer_core (
  input  wire logic        clk,
  input  wire logic        rst,

  // input frames
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] mic_left,
  input  wire logic [15:0] mic_right,
  input  wire logic [15:0] music_left,
  input  wire logic [15:0] music_right,
  input  wire logic        music_present,
  input  wire logic        block_end,

  // mixed frames
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_left,
  output logic [15:0]      out_right,
  output logic             frame_last,

  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // configuration registers
  logic                          echo_running;
  logic [fem_pkg::LEN_W-1:0]     delay_length;
  logic [fem_pkg::GAIN_W-1:0]    mic_gain;
  logic [fem_pkg::GAIN_W-1:0]    music_gain;

  fem_pkg::reg_idx_t             cfg_idx;
  logic                          cfg_we;
  logic                          restart;

  // read pointer, walks down and wraps to the delay length
  fem_pkg::addr_t                tap_index;
  fem_pkg::addr_t                tap_index_next;

  // stage one: item waiting for its tap
  logic                          s1_valid;
  fem_pkg::addr_t                s1_addr;
  fem_pkg::sample_t              s1_mic_left;
  fem_pkg::sample_t              s1_mic_right;
  fem_pkg::sample_t              s1_music_left;
  fem_pkg::sample_t              s1_music_right;
  logic                          s1_music_present;
  logic                          s1_block_end;

  logic                          accept;
  logic                          s1_adv;
  logic                          dl_busy;
  fem_pkg::dl_req_t              dl_req;
  fem_pkg::sample_t              tap;
  fem_pkg::mix_res_t             mix;

  // ---------------------------------------------------------------- registers
  assign pready  = 1'b1;
  assign cfg_idx = fem_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_we  = psel && penable && pwrite;
  assign restart = cfg_we && (cfg_idx == fem_pkg::REG_ECHO_RUNNING ||
                              cfg_idx == fem_pkg::REG_DELAY_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_running <= 1'b0;
      delay_length <= fem_pkg::DELAY_LENGTH_RST;
      mic_gain     <= fem_pkg::MIC_GAIN_RST;
      music_gain   <= fem_pkg::MUSIC_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        fem_pkg::REG_ECHO_RUNNING: echo_running <= pwdata[0];
        fem_pkg::REG_DELAY_LENGTH: delay_length <= pwdata[fem_pkg::LEN_W-1:0];
        fem_pkg::REG_MIC_GAIN:     mic_gain     <= pwdata[fem_pkg::GAIN_W-1:0];
        fem_pkg::REG_MUSIC_GAIN:   music_gain   <= pwdata[fem_pkg::GAIN_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      fem_pkg::REG_ECHO_RUNNING: prdata = {31'd0, echo_running};
      fem_pkg::REG_DELAY_LENGTH: prdata = 32'(delay_length);
      fem_pkg::REG_MIC_GAIN:     prdata = 32'(mic_gain);
      fem_pkg::REG_MUSIC_GAIN:   prdata = 32'(music_gain);
    endcase
  end

  // ---------------------------------------------------------------- handshake
  // stage one drains into the output register whenever that register is
  // empty or being taken, so a waiting result does not block the next item
  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = dl_busy || (s1_valid && !s1_adv);
  assign accept   = in_valid && !in_stall;

  // ---------------------------------------------------------------- pointer
  always_comb begin
    tap_index_next = tap_index;
    priority if (restart) begin
      if (cfg_idx == fem_pkg::REG_DELAY_LENGTH) begin
        tap_index_next = fem_pkg::eff_len(pwdata[fem_pkg::LEN_W-1:0]);
      end else begin
        tap_index_next = fem_pkg::eff_len(delay_length);
      end
    end else if (accept && echo_running) begin
      if (tap_index == '0) begin
        tap_index_next = fem_pkg::eff_len(delay_length);
      end else begin
        tap_index_next = tap_index - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_index <= fem_pkg::eff_len(fem_pkg::DELAY_LENGTH_RST);
    end else begin
      tap_index <= tap_index_next;
    end
  end

  // ---------------------------------------------------------------- stage one
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr          <= tap_index;
      s1_mic_left      <= mic_left;
      s1_mic_right     <= mic_right;
      s1_music_left    <= music_left;
      s1_music_right   <= music_right;
      s1_music_present <= music_present;
      s1_block_end     <= block_end;
    end
  end

  // tap is read when the item is taken, feedback written when it moves on
  assign dl_req.rd_en   = accept;
  assign dl_req.rd_addr = tap_index;
  assign dl_req.wr_en   = s1_adv && echo_running;
  assign dl_req.wr_addr = s1_addr;
  assign dl_req.wr_data = mix.feedback;

  fem_delay_line u_delay_line (
    .clk         (clk),
    .rst         (rst),
    .clear_start (restart),
    .req         (dl_req),
    .rd_data     (tap),
    .busy        (dl_busy)
  );

  fem_mix u_mix (
    .tap           (tap),
    .mic_left      (s1_mic_left),
    .mic_right     (s1_mic_right),
    .music_left    (s1_music_left),
    .music_right   (s1_music_right),
    .music_present (s1_music_present),
    .mic_gain      (mic_gain),
    .music_gain    (music_gain),
    .res           (mix)
  );

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_left   <= mix.out_left;
      out_right  <= mix.out_right;
      frame_last <= s1_block_end;
    end
  end

  // ---------------------------------------------------------------- checks
  // a run or length write always starts a fresh zeroing sweep
  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    restart |=> dl_busy)
    else $error("restart did not start the delay line sweep");

  // no item enters while the store is being zeroed
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    dl_busy |-> !accept)
    else $error("item accepted during delay line sweep");

  // with echo stopped the pointer is frozen
  a_frozen_ptr: assert property (@(posedge clk) disable iff (rst)
    (!echo_running && !restart) |=> $stable(tap_index))
    else $error("tap pointer moved while echo stopped");

  // every item leaving stage one lands in the output register
  a_stage_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("result lost between stage one and output");

  // the pointer never leaves the store
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    accept |-> (32'(tap_index) < fem_pkg::DELAY_DEPTH))
    else $error("tap pointer beyond delay line");

endmodule

`default_nettype wire

// ===== bench/tb_feedback_echo_mixer_core.sv =====
`timescale 1ns / 1ps

module tb_feedback_echo_mixer_core;

  localparam int IDLE_LIMIT  = 30000;  // covers the clearing sweep of all 8192 entries with margin
  localparam int HOLD_CYCLES = 400;
  localparam int PRINT_CAP   = 50;

  typedef struct packed {
    logic [15:0] mic_l;
    logic [15:0] mic_r;
    logic [15:0] mus_l;
    logic [15:0] mus_r;
    logic        music;
    logic        last;
  } frame_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic        last;
  } mix_out_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // block ports
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [15:0] mic_left      = '0;
  logic [15:0] mic_right     = '0;
  logic [15:0] music_left    = '0;
  logic [15:0] music_right   = '0;
  logic        music_present = 1'b0;
  logic        block_end     = 1'b0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [15:0] out_left;
  logic [15:0] out_right;
  logic        frame_last;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [3:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  feedback_echo_mixer_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mic_left      (mic_left),
    .mic_right     (mic_right),
    .music_left    (music_left),
    .music_right   (music_right),
    .music_present (music_present),
    .block_end     (block_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_left      (out_left),
    .out_right     (out_right),
    .frame_last    (frame_last),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // frames waiting to be offered, and mixed frames still owed by the block
  frame_t   pending_frames[$];
  mix_out_t mix_expected[$];

  // idling knobs, percent per cycle
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // long receiver hold-off, timed in its own process
  logic hold_go  = 1'b0;
  int   hold_cnt = 0;
  logic holding;

  int err_count      = 0;
  int frames_taken   = 0;
  int results_seen   = 0;
  int settings_count = 1;
  int idle_cycles    = 0;

  // shadow of the echo line and registers
  logic signed [15:0] echo_line [fem_pkg::DELAY_DEPTH];
  int line_ptr;
  bit echo_on;
  int dly_len;
  int mic_g;
  int mus_g;

  function automatic int clip16(input int v);
    if (v > 32767) begin
      return 32767;
    end
    if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  // both run and delay writes wipe the line and reload the pointer
  function automatic void restart_echo();
    foreach (echo_line[i]) begin
      echo_line[i] = '0;
    end
    line_ptr = (dly_len >= fem_pkg::DELAY_DEPTH) ? fem_pkg::DELAY_DEPTH - 1 : dly_len;
  endfunction

  // work out the mixed frame for one accepted input frame and advance the line
  function automatic void mix_frame(input frame_t f);
    int tap;
    int wet;
    int left;
    int right;
    int idx;
    mix_out_t r;
    idx = line_ptr;
    tap = int'(echo_line[idx]);
    // arithmetic shift on int gives floor division by a power of two
    wet = clip16(((tap + int'($signed(f.mic_l))) * mic_g) >>> 4);
    if (f.music) begin
      left  = clip16(((int'($signed(f.mus_l)) * mus_g) >>> 4) + wet);
      right = clip16(((int'($signed(f.mus_r)) * mus_g) >>> 4) + wet);
    end else begin
      left  = wet;
      right = wet;
    end
    if (echo_on) begin
      echo_line[idx] = 16'(clip16((tap >>> 1) + int'($signed(f.mic_r))));
      line_ptr = (idx == 0)
          ? ((dly_len >= fem_pkg::DELAY_DEPTH) ? fem_pkg::DELAY_DEPTH - 1 : dly_len)
          : idx - 1;
    end
    r.left  = left[15:0];
    r.right = right[15:0];
    r.last  = f.last;
    mix_expected.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (err_count < PRINT_CAP) begin
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    end
    err_count++;
  endtask

  // input side: offer the next frame once the current one is taken
  always @(posedge clk) begin : drive_frames
    frame_t f;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        mix_frame('{mic_left, mic_right, music_left, music_right, music_present, block_end});
        frames_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_frames.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          f = pending_frames.pop_front();
          mic_left      <= f.mic_l;
          mic_right     <= f.mic_r;
          music_left    <= f.mus_l;
          music_right   <= f.mus_r;
          music_present <= f.music;
          block_end     <= f.last;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side: check each mixed frame against the oldest expectation
  always @(posedge clk) begin : check_results
    mix_out_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (mix_expected.size() == 0) begin
          report_mismatch("result with nothing owed", {out_left, out_right}, '0);
        end else begin
          e = mix_expected.pop_front();
          if (out_left !== e.left) begin
            report_mismatch("out_left", out_left, e.left);
          end
          if (out_right !== e.right) begin
            report_mismatch("out_right", out_right, e.right);
          end
          if (frame_last !== e.last) begin
            report_mismatch("frame_last", frame_last, e.last);
          end
        end
      end
      out_stall <= holding || ($urandom_range(99) < stall_pct);
    end
  end

  // hold-off counter for the back-pressure phase
  always @(posedge clk) begin
    if (rst || !hold_go) begin
      hold_cnt <= 0;
    end else if (hold_cnt < HOLD_CYCLES) begin
      hold_cnt <= hold_cnt + 1;
    end
  end

  assign holding = hold_go && (hold_cnt < HOLD_CYCLES);

  // watchdog: only counts while something is still in flight
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (pending_frames.size() != 0 || in_valid || mix_expected.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("feedback_echo_mixer_core verification failed");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  // register write with setup and access cycles, then read it back
  task automatic write_reg(input fem_pkg::reg_idx_t idx, input int unsigned value);
    logic [31:0] masked;
    case (idx)
      fem_pkg::REG_ECHO_RUNNING: masked = value & 32'h1;
      fem_pkg::REG_DELAY_LENGTH: masked = value & ((32'h1 << fem_pkg::LEN_W) - 1);
      default:                   masked = value & ((32'h1 << fem_pkg::GAIN_W) - 1);
    endcase
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // write lands at this edge
    case (idx)
      fem_pkg::REG_ECHO_RUNNING: begin
        echo_on = masked[0];
        restart_echo();
      end
      fem_pkg::REG_DELAY_LENGTH: begin
        dly_len = int'(masked);
        restart_echo();
      end
      fem_pkg::REG_MIC_GAIN:     mic_g = int'(masked);
      fem_pkg::REG_MUSIC_GAIN:   mus_g = int'(masked);
      default: ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== masked) begin
      report_mismatch("register readback", prdata, masked);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_echo(input bit run, input int dly, input int mg, input int mug);
    write_reg(fem_pkg::REG_ECHO_RUNNING, run);
    write_reg(fem_pkg::REG_DELAY_LENGTH, dly);
    write_reg(fem_pkg::REG_MIC_GAIN, mg);
    write_reg(fem_pkg::REG_MUSIC_GAIN, mug);
    settings_count++;
  endtask

  task automatic set_idling(input int sender, input int receiver);
    @(posedge clk);
    send_idle_pct <= sender;
    stall_pct     <= receiver;
  endtask

  // block drained: nothing queued, offered or owed
  task automatic wait_quiet();
    while (pending_frames.size() != 0 || in_valid || mix_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // samples lean toward the rails and small values so saturation shows up
  function automatic logic [15:0] rand_sample();
    int pick;
    pick = $urandom_range(9);
    case (pick)
      0:       return fem_pkg::SAMPLE_MAX;
      1:       return fem_pkg::SAMPLE_MIN;
      2:       return 16'($signed($urandom_range(16)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_random(input int n);
    frame_t f;
    @(negedge clk);
    repeat (n) begin
      f.mic_l = rand_sample();
      f.mic_r = rand_sample();
      f.mus_l = rand_sample();
      f.mus_r = rand_sample();
      f.music = ($urandom_range(9) < 7);
      f.last  = ($urandom_range(9) == 0);
      pending_frames.push_back(f);
    end
  endtask

  task automatic push_frame(input logic [15:0] ml, input logic [15:0] mr,
                            input logic [15:0] sl, input logic [15:0] sr,
                            input logic music, input logic last);
    pending_frames.push_back('{ml, mr, sl, sr, music, last});
  endtask

  initial begin
    // reset state of the shadow
    echo_on = 1'b0;
    dly_len = int'(fem_pkg::DELAY_LENGTH_RST);
    mic_g   = int'(fem_pkg::MIC_GAIN_RST);
    mus_g   = int'(fem_pkg::MUSIC_GAIN_RST);
    restart_echo();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset register values, echo stopped: rails, zero, music on and off
    @(negedge clk);
    push_frame('0, '0, '0, '0, 1'b0, 1'b0);
    push_frame(fem_pkg::SAMPLE_MAX, fem_pkg::SAMPLE_MAX, '0, '0, 1'b0, 1'b1);
    push_frame(fem_pkg::SAMPLE_MIN, fem_pkg::SAMPLE_MIN, '0, '0, 1'b0, 1'b0);
    push_frame(fem_pkg::SAMPLE_MAX, '0, fem_pkg::SAMPLE_MAX, fem_pkg::SAMPLE_MAX,
               1'b1, 1'b0);
    push_frame(fem_pkg::SAMPLE_MIN, '0, fem_pkg::SAMPLE_MIN, fem_pkg::SAMPLE_MIN,
               1'b1, 1'b1);
    push_frame(fem_pkg::SAMPLE_MAX, '0, fem_pkg::SAMPLE_MIN, fem_pkg::SAMPLE_MAX,
               1'b1, 1'b0);
    push_frame(16'hffff, 16'h0001, 16'h0001, 16'hffff, 1'b1, 1'b0);
    push_frame(16'hfff1, '0, 16'hfff1, 16'h000f, 1'b1, 1'b1);
    push_frame(16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 1'b0, 1'b0);
    push_frame(16'haaaa, 16'h5555, 16'h5555, 16'haaaa, 1'b1, 1'b1);

    // one-frame delay with full gains: feedback saturates in both directions
    wait_quiet();
    set_echo(1'b1, 0, 255, 255);
    @(negedge clk);
    push_frame('0, fem_pkg::SAMPLE_MAX, '0, '0, 1'b0, 1'b0);
    push_frame('0, fem_pkg::SAMPLE_MAX, '0, '0, 1'b0, 1'b0);
    push_frame('0, fem_pkg::SAMPLE_MAX, '0, '0, 1'b1, 1'b1);
    push_frame(fem_pkg::SAMPLE_MIN, fem_pkg::SAMPLE_MIN, fem_pkg::SAMPLE_MIN,
               fem_pkg::SAMPLE_MAX, 1'b1, 1'b0);
    push_frame(fem_pkg::SAMPLE_MIN, fem_pkg::SAMPLE_MIN, '0, '0, 1'b0, 1'b0);
    push_frame(fem_pkg::SAMPLE_MIN, fem_pkg::SAMPLE_MIN, '0, '0, 1'b0, 1'b0);
    push_frame(fem_pkg::SAMPLE_MAX, fem_pkg::SAMPLE_MIN, fem_pkg::SAMPLE_MAX,
               fem_pkg::SAMPLE_MIN, 1'b1, 1'b1);
    push_frame(16'h0001, 16'h0003, 16'hffff, 16'h0001, 1'b1, 1'b0);
    push_frame(16'hffff, 16'hfffd, 16'h0001, 16'hffff, 1'b0, 1'b0);
    push_frame('0, '0, '0, '0, 1'b1, 1'b0);
    push_random(200);

    // short delay, unity gains, sender mostly idle
    wait_quiet();
    set_echo(1'b1, 5, 16, 16);
    set_idling(60, 0);
    push_random(250);

    // longest delay, zero gains, receiver stalling
    wait_quiet();
    set_echo(1'b1, (1 << fem_pkg::LEN_W) - 1, 0, 0);
    set_idling(0, 60);
    push_random(150);

    // echo stopped: line and pointer stay put
    wait_quiet();
    set_echo(1'b0, 3, 33, 200);
    set_idling(8, 8);
    push_random(150);

    // back-pressure: receiver holds off while the sender keeps offering
    wait_quiet();
    set_echo(1'b1, 1, 255, 1);
    set_idling(0, 0);
    push_random(20);
    wait_quiet();
    @(posedge clk);
    hold_go <= 1'b1;
    push_random(120);
    while (hold_cnt < HOLD_CYCLES) @(posedge clk);
    hold_go <= 1'b0;
    set_idling(0, 60);
    push_random(130);

    // mid-length delay, random gains, then a gain-only change that keeps the line
    wait_quiet();
    set_echo(1'b1, 16, $urandom_range(255), $urandom_range(255));
    set_idling(8, 8);
    push_random(150);
    wait_quiet();
    write_reg(fem_pkg::REG_MIC_GAIN, $urandom_range(255));
    write_reg(fem_pkg::REG_MUSIC_GAIN, $urandom_range(255));
    settings_count++;
    set_idling(0, 0);
    push_random(150);

    wait_quiet();
    repeat (10) @(posedge clk);

    $display("run covered %0d frames and %0d checked results over %0d register settings,",
             frames_taken, results_seen, settings_count);
    $display("with idle sender, stalled receiver, a long hold-off and %0d mismatches",
             err_count);
    if (err_count == 0) begin
      $display("feedback_echo_mixer_core verification clean");
    end else begin
      $display("feedback_echo_mixer_core verification failed");
    end
    $finish;
  end

endmodule
